/* rtl/assert_macros.svh */
// Assertion macros shared by the console line timestamper RTL.
// Depends on nothing; a user module must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside of reset.
`define CLTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define CLTS_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CLTS_ASSERT(lbl, prop, msg)
`define CLTS_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

/* rtl/clts_pkg.sv */
// Package of the console line timestamper: widths, character codes,
// reciprocal constants, item types and small decimal helpers. No dependencies.
package clts_pkg;

  localparam int CHAR_W      = 8;
  localparam int TIME_W      = 32;
  localparam int STAMP_LEN   = 12;   // "[MM:SS.mmm] "
  localparam int IDX_W       = 4;    // covers 0 .. STAMP_LEN
  localparam int QDEPTH      = 4;    // power of two, pointers wrap naturally
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int PIPE_STAGES = 5;    // time conversion stages after the front register
  localparam int MIN_W       = 17;   // full minute count of a 32-bit ms value

  // Character codes
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [3:0]        CH_DIGIT_HI = 4'h3;  // upper nibble of '0'..'9'

  // Time constants
  localparam logic [15:0] MS_PER_MIN   = 16'd60000;
  localparam logic [9:0]  MS_PER_S     = 10'd1000;
  localparam logic [6:0]  C100         = 7'd100;
  localparam logic [3:0]  DEC_BASE     = 4'd10;
  // (t >> 5) / 1875 == t / 60000; exact for 27-bit operands
  localparam logic [27:0] MIN_RECIP    = 28'd146601551;
  localparam int          MIN_RECIP_SH = 38;
  // (m >> 2) / 25 == m / 100; exact for 15-bit operands, shift 20
  localparam logic [15:0] C100_RECIP   = 16'd41944;
  // (r >> 3) / 125 == r / 1000; exact for 13-bit operands, shift 20
  localparam logic [13:0] SEC_RECIP    = 14'd8389;
  // v / 10 for v < 1029, shift 11
  localparam logic [7:0]  DIV10_RECIP  = 8'd205;

  typedef logic [3:0] digit_t;

  typedef enum logic [1:0] {
    KIND_PLAIN,   // the character alone
    KIND_CRLF,    // CR inserted ahead of the line feed
    KIND_STAMP    // stamp, then the character
  } kind_e;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    kind_e             kind;
  } tag_t;

  typedef struct packed {
    tag_t   tag;
    digit_t min_t;
    digit_t min_o;
    digit_t sec_t;
    digit_t sec_o;
    digit_t ms_h;
    digit_t ms_t;
    digit_t ms_o;
  } item_t;

  function automatic logic [6:0] div10(input logic [9:0] v);
    logic [17:0] p;
    p = 18'(v) * 18'(DIV10_RECIP);
    return p[17:11];
  endfunction

  // Split a value below 100 into tens and ones.
  function automatic logic [7:0] dec2(input logic [6:0] v);
    logic [6:0] q;
    logic [6:0] r;
    q = div10({3'b000, v});
    r = v - 7'(q * 7'(DEC_BASE));
    return {q[3:0], r[3:0]};
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input digit_t d);
    return {CH_DIGIT_HI, d};
  endfunction

  // Index of the final output transaction of an item.
  function automatic logic [IDX_W-1:0] last_idx(input kind_e k);
    logic [IDX_W-1:0] r;
    unique case (k)
      KIND_PLAIN: r = '0;
      KIND_CRLF:  r = IDX_W'(1);
      KIND_STAMP: r = IDX_W'(STAMP_LEN);
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/clts_if.sv */
// Channel interfaces of the console line timestamper: input, output and config.
// Depends on clts_pkg for the field widths.
interface clts_in_if;
  logic                         valid;
  logic                         ready;
  logic [clts_pkg::CHAR_W-1:0]  char_in;
  logic [clts_pkg::TIME_W-1:0]  time_ms;
  modport source (output valid, char_in, time_ms, input ready);
  modport sink   (input valid, char_in, time_ms, output ready);
endinterface

interface clts_out_if;
  logic                         valid;
  logic                         ready;
  logic [clts_pkg::CHAR_W-1:0]  char_out;
  logic                         last;
  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface

interface clts_cfg_if;
  logic valid;
  logic ready;
  logic expand_newline;
  modport source (output valid, expand_newline, input ready);
  modport sink   (input valid, expand_newline, output ready);
endinterface

/* rtl/console_line_timestamper_unit.sv */
// Top level of the console line timestamper.
// Depends on clts_pkg, clts_if.sv, clts_front, clts_time_pipe, clts_fifo, clts_back.

// Each accepted transaction carries one console byte and the millisecond
// count. The unit emits 1, 2 or 13 output transactions per input: the byte
// alone; CR then LF for a line feed while expand_newline is 1 (reset value);
// or the stamp "[MM:SS.mmm] " followed by the byte for the first character of
// a line other than CR or LF. Minutes show modulo 100; a line feed returns to
// line start, so blank lines stay bare, and a CR at line start passes bare.
// last marks the final output transaction of each input. Throughput is one
// output transaction per cycle, set by the single output register; plain
// bytes therefore flow at one per cycle with both sides streaming. A stamped
// line start takes 13 output transactions, and the input keeps accepting
// until the 4-entry queue and the 6-stage front pipeline are full. The path
// from input acceptance to the first output transaction runs through the
// front register, five stages of time conversion, the queue write and the
// output register. Write expand_newline only while the unit is drained; the
// write takes effect for the next accepted byte.
module console_line_timestamper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  clts_cfg_if.sink    cfg_i,
  clts_in_if.sink     in_i,
  clts_out_if.source  out_o
);

  logic                         adv;
  logic                         s1_vld;
  clts_pkg::tag_t               s1_tag;
  logic [clts_pkg::TIME_W-1:0]  s1_time;
  logic                         push;
  clts_pkg::item_t              push_item;
  logic                         pop;
  logic                         fifo_full;
  logic                         fifo_empty;
  clts_pkg::item_t              head;

  // Accept, classify and track the line position.
  clts_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .in_i      (in_i),
    .adv_i     (adv),
    .s1_vld_o  (s1_vld),
    .s1_tag_o  (s1_tag),
    .s1_time_o (s1_time)
  );

  // Convert the time to stamp digits; hold the whole front when the queue is full and the last stage holds an item.
  clts_time_pipe u_time_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_vld_i    (s1_vld),
    .s1_tag_i    (s1_tag),
    .s1_time_i   (s1_time),
    .fifo_full_i (fifo_full),
    .adv_o       (adv),
    .push_o      (push),
    .item_o      (push_item)
  );

  // Decouple classification from character emission.
  clts_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty),
    .head_o      (head)
  );

  // Emit one character per cycle while the output is ready; drop the queue head after its last one.
  clts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

/* rtl/clts_front.sv */
// Front end: config register, input acceptance, line tracking and classification.
// Depends on clts_pkg and the channel interfaces in clts_if.sv.
module clts_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  clts_cfg_if.sink                      cfg_i,
  clts_in_if.sink                       in_i,
  input  logic                          adv_i,
  output logic                          s1_vld_o,
  output clts_pkg::tag_t                s1_tag_o,
  output logic [clts_pkg::TIME_W-1:0]   s1_time_o
);

  logic                         expand_q;
  logic                         mid_q;
  logic                         mid_d;
  logic                         vld_q;
  logic                         in_fire;
  clts_pkg::tag_t               tag_d;
  clts_pkg::tag_t               tag_q;
  logic [clts_pkg::TIME_W-1:0]  time_q;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = adv_i;
  assign in_fire     = in_i.valid && adv_i;

  // Classify the character and advance the mid-line flag.
  always_comb begin
    mid_d       = mid_q;
    tag_d.ch    = in_i.char_in;
    tag_d.kind  = clts_pkg::KIND_PLAIN;
    priority if (in_i.char_in == clts_pkg::CH_LF) begin
      mid_d = 1'b0;
      if (expand_q) begin
        tag_d.kind = clts_pkg::KIND_CRLF;
      end
    end else if (in_i.char_in == clts_pkg::CH_CR) begin
      mid_d = mid_q;
    end else if (!mid_q) begin
      tag_d.kind = clts_pkg::KIND_STAMP;
      mid_d      = 1'b1;
    end else begin
      mid_d = mid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expand_q <= 1'b1;
      mid_q    <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        expand_q <= cfg_i.expand_newline;
      end
      if (adv_i) begin
        vld_q <= in_i.valid;
      end
      if (in_fire) begin
        mid_q <= mid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tag_q  <= tag_d;
      time_q <= in_i.time_ms;
    end
  end

  assign s1_vld_o  = vld_q;
  assign s1_tag_o  = tag_q;
  assign s1_time_o = time_q;

endmodule

/* rtl/clts_time_pipe.sv */
// Time conversion pipeline: milliseconds to MM:SS.mmm digits.
// Depends on clts_pkg.
module clts_time_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s1_vld_i,
  input  clts_pkg::tag_t                s1_tag_i,
  input  logic [clts_pkg::TIME_W-1:0]   s1_time_i,
  input  logic                          fifo_full_i,
  output logic                          adv_o,
  output logic                          push_o,
  output clts_pkg::item_t               item_o
);

  logic [clts_pkg::PIPE_STAGES-1:0] vld_q;

  // Stage 2: full minutes
  clts_pkg::tag_t               s2_tag_q;
  logic [clts_pkg::TIME_W-1:0]  s2_time_q;
  logic [clts_pkg::MIN_W-1:0]   s2_min_q;
  logic [54:0]                  min_prod;

  // Stage 3: remainder in ms, minutes / 100
  clts_pkg::tag_t               s3_tag_q;
  logic [clts_pkg::MIN_W-1:0]   s3_min_q;
  logic [15:0]                  s3_rem_q;
  logic [9:0]                   s3_q100_q;
  logic [32:0]                  mms_prod;
  logic [31:0]                  rem_full;
  logic [30:0]                  q_prod;

  // Stage 4: seconds, minutes mod 100
  clts_pkg::tag_t               s4_tag_q;
  logic [15:0]                  s4_rem_q;
  logic [5:0]                   s4_sec_q;
  logic [6:0]                   s4_r100_q;
  logic [26:0]                  sec_prod;
  logic [16:0]                  r100_full;

  // Stage 5: milliseconds, minute and second digits
  clts_pkg::tag_t               s5_tag_q;
  logic [9:0]                   s5_ms_q;
  logic [7:0]                   s5_min_dig_q;
  logic [7:0]                   s5_sec_dig_q;
  logic [15:0]                  ms_full;

  // Stage 6: ms / 10 and ms ones digit
  clts_pkg::tag_t               s6_tag_q;
  logic [6:0]                   s6_msd_q;
  clts_pkg::digit_t             s6_ms_o_q;
  logic [7:0]                   s6_min_dig_q;
  logic [7:0]                   s6_sec_dig_q;
  logic [6:0]                   msd_d;
  logic [9:0]                   ms_o_full;
  logic [7:0]                   ms_ht;

  assign adv_o  = !vld_q[clts_pkg::PIPE_STAGES-1] || !fifo_full_i;
  assign push_o = vld_q[clts_pkg::PIPE_STAGES-1] && !fifo_full_i;

  assign min_prod  = 55'(s1_time_i[clts_pkg::TIME_W-1:5]) * 55'(clts_pkg::MIN_RECIP);
  assign mms_prod  = 33'(s2_min_q) * 33'(clts_pkg::MS_PER_MIN);
  assign rem_full  = s2_time_q - mms_prod[31:0];
  assign q_prod    = 31'(s2_min_q[clts_pkg::MIN_W-1:2]) * 31'(clts_pkg::C100_RECIP);
  assign sec_prod  = 27'(s3_rem_q[15:3]) * 27'(clts_pkg::SEC_RECIP);
  assign r100_full = s3_min_q - 17'(s3_q100_q) * 17'(clts_pkg::C100);
  assign ms_full   = s4_rem_q - 16'(s4_sec_q) * 16'(clts_pkg::MS_PER_S);
  assign msd_d     = clts_pkg::div10(s5_ms_q);
  assign ms_o_full = s5_ms_q - 10'(msd_d) * 10'(clts_pkg::DEC_BASE);
  assign ms_ht     = clts_pkg::dec2(s6_msd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_o) begin
      vld_q <= {vld_q[clts_pkg::PIPE_STAGES-2:0], s1_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s2_tag_q     <= s1_tag_i;
      s2_time_q    <= s1_time_i;
      s2_min_q     <= min_prod[clts_pkg::MIN_RECIP_SH +: clts_pkg::MIN_W];

      s3_tag_q     <= s2_tag_q;
      s3_min_q     <= s2_min_q;
      s3_rem_q     <= rem_full[15:0];
      s3_q100_q    <= q_prod[29:20];

      s4_tag_q     <= s3_tag_q;
      s4_rem_q     <= s3_rem_q;
      s4_sec_q     <= sec_prod[25:20];
      s4_r100_q    <= r100_full[6:0];

      s5_tag_q     <= s4_tag_q;
      s5_ms_q      <= ms_full[9:0];
      s5_min_dig_q <= clts_pkg::dec2(s4_r100_q);
      s5_sec_dig_q <= clts_pkg::dec2({1'b0, s4_sec_q});

      s6_tag_q     <= s5_tag_q;
      s6_msd_q     <= msd_d;
      s6_ms_o_q    <= ms_o_full[3:0];
      s6_min_dig_q <= s5_min_dig_q;
      s6_sec_dig_q <= s5_sec_dig_q;
    end
  end

  always_comb begin
    item_o.tag   = s6_tag_q;
    item_o.min_t = s6_min_dig_q[7:4];
    item_o.min_o = s6_min_dig_q[3:0];
    item_o.sec_t = s6_sec_dig_q[7:4];
    item_o.sec_o = s6_sec_dig_q[3:0];
    item_o.ms_h  = ms_ht[7:4];
    item_o.ms_t  = ms_ht[3:0];
    item_o.ms_o  = s6_ms_o_q;
  end

endmodule

/* rtl/clts_fifo.sv */
// Short queue of classified items between the front end and the character emitter.
// Depends on clts_pkg.
module clts_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  clts_pkg::item_t  push_item_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output clts_pkg::item_t  head_o
);

  clts_pkg::item_t              mem_q [clts_pkg::QDEPTH];
  logic [clts_pkg::QPTR_W-1:0]  wr_ptr_q;
  logic [clts_pkg::QPTR_W-1:0]  rd_ptr_q;
  logic [clts_pkg::QCNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == clts_pkg::QCNT_W'(clts_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + clts_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + clts_pkg::QPTR_W'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + clts_pkg::QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - clts_pkg::QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/clts_back.sv */
// Back end: walks the queue head through its output characters into the output register.
// Depends on clts_pkg, clts_if.sv and assert_macros.svh.
`include "assert_macros.svh"

module clts_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fifo_empty_i,
  input  clts_pkg::item_t  head_i,
  output logic             pop_o,
  clts_out_if.source       out_o
);

  logic                          out_vld_q;
  logic [clts_pkg::CHAR_W-1:0]   out_char_q;
  logic                          out_last_q;
  logic [clts_pkg::IDX_W-1:0]    idx_q;
  logic                          load;
  logic                          last_c;
  logic [clts_pkg::CHAR_W-1:0]   char_c;
  logic [clts_pkg::CHAR_W-1:0]   stamp_c [clts_pkg::STAMP_LEN];

  assign load   = !fifo_empty_i && (!out_vld_q || out_o.ready);
  assign last_c = (idx_q == clts_pkg::last_idx(head_i.tag.kind));
  assign pop_o  = load && last_c;

  always_comb begin
    stamp_c[0]  = clts_pkg::CH_LBRACK;
    stamp_c[1]  = clts_pkg::digit_char(head_i.min_t);
    stamp_c[2]  = clts_pkg::digit_char(head_i.min_o);
    stamp_c[3]  = clts_pkg::CH_COLON;
    stamp_c[4]  = clts_pkg::digit_char(head_i.sec_t);
    stamp_c[5]  = clts_pkg::digit_char(head_i.sec_o);
    stamp_c[6]  = clts_pkg::CH_DOT;
    stamp_c[7]  = clts_pkg::digit_char(head_i.ms_h);
    stamp_c[8]  = clts_pkg::digit_char(head_i.ms_t);
    stamp_c[9]  = clts_pkg::digit_char(head_i.ms_o);
    stamp_c[10] = clts_pkg::CH_RBRACK;
    stamp_c[11] = clts_pkg::CH_SPACE;
  end

  always_comb begin
    unique case (head_i.tag.kind)
      clts_pkg::KIND_PLAIN: char_c = head_i.tag.ch;
      clts_pkg::KIND_CRLF:  char_c = (idx_q == '0) ? clts_pkg::CH_CR : head_i.tag.ch;
      clts_pkg::KIND_STAMP: begin
        if (idx_q < clts_pkg::IDX_W'(clts_pkg::STAMP_LEN)) begin
          char_c = stamp_c[idx_q];
        end else begin
          char_c = head_i.tag.ch;
        end
      end
      default:              char_c = head_i.tag.ch;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (load) begin
      out_vld_q <= 1'b1;
      idx_q     <= last_c ? '0 : idx_q + clts_pkg::IDX_W'(1);
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= char_c;
      out_last_q <= last_c;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.char_out = out_char_q;
  assign out_o.last     = out_last_q;

  `CLTS_ASSERT(a_idx_idle, fifo_empty_i |-> (idx_q == '0), "index left mid-item on empty queue")
  `CLTS_ASSERT(a_idx_range, !fifo_empty_i |-> (idx_q <= clts_pkg::last_idx(head_i.tag.kind)), "index past item end")
  `CLTS_ASSERT(a_idx_hold, (out_vld_q && !out_o.ready) |=> $stable(idx_q), "index moved under stall")
  `CLTS_ASSERT_NORST(a_rst_idx, !rst_ni |-> (idx_q == '0), "index not cleared in reset")

endmodule
